// File: sv/tsfs_pkg.sv
// Package for the touch sample filter and scaler.
// Holds the widths, register codes, reset values and payload types.
// The interfaces, all modules and the checker depend on this file.
package tsfs_pkg;

  localparam int SAMPLES_PER_AXIS = 5;
  localparam int SAMPLE_SHIFT     = 4;
  localparam int WORD_W           = 16;
  localparam int SAMPLE_W         = 12;
  localparam int COORD_W          = 12;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 12;

  // Sum of all kept samples, count of kept samples, numerator of the scaling.
  localparam int SUM_W = $clog2(SAMPLES_PER_AXIS * (2 ** SAMPLE_W));
  localparam int CNT_W = $clog2(SAMPLES_PER_AXIS + 1);
  localparam int NUM_W = SUM_W + COORD_W;

  // Divider: quotient bits resolved per stage.
  localparam int DIV_STEPS    = 2;
  localparam int DIV_STAGES   = COORD_W / DIV_STEPS;
  localparam int FRONT_STAGES = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_USE_PEN_IRQ   = 3'd0,
    CFG_MIN_RAW_X     = 3'd1,
    CFG_MAX_RAW_X     = 3'd2,
    CFG_MIN_RAW_Y     = 3'd3,
    CFG_MAX_RAW_Y     = 3'd4,
    CFG_SCREEN_WIDTH  = 3'd5,
    CFG_SCREEN_HEIGHT = 3'd6
  } cfg_addr_e;

  localparam logic [SAMPLE_W-1:0] RST_MIN_RAW       = 12'd0;
  localparam logic [SAMPLE_W-1:0] RST_MAX_RAW       = 12'd4095;
  localparam logic [COORD_W-1:0]  RST_SCREEN_WIDTH  = 12'd320;
  localparam logic [COORD_W-1:0]  RST_SCREEN_HEIGHT = 12'd240;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [SAMPLES_PER_AXIS-1:0] axis_words_t;

  typedef struct packed {
    logic  pen_up;
    word_t x_word_0;
    word_t x_word_1;
    word_t x_word_2;
    word_t x_word_3;
    word_t x_word_4;
    word_t y_word_0;
    word_t y_word_1;
    word_t y_word_2;
    word_t y_word_3;
    word_t y_word_4;
  } in_item_t;

  typedef struct packed {
    logic               touched;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } out_item_t;

  // Calibration window and screen size of one axis.
  typedef struct packed {
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [COORD_W-1:0]  size;
  } axis_cfg_t;

endpackage

// File: sv/tsfs_if.sv
// Handshake interfaces of the touch sample filter and scaler.
// Input items, result items and configuration writes each use one.
// Depends on tsfs_pkg.
interface tsfs_in_if;
  logic               valid;
  logic               ready;
  tsfs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsfs_out_if;
  logic                valid;
  logic                ready;
  tsfs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsfs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tsfs_pkg::CFG_ADDR_W-1:0]     addr;
  logic [tsfs_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// File: sv/touch_sample_filter_scale_top.sv
// Touch sample filter and scaler, top level.
// From an input transfer to its result, an item passes through four front-end
// stages, six divider stages of two quotient bits each, and the output register.
// One item is accepted per cycle until a stalled output has filled the empty stages.
// Reset (rst_ni low, asynchronous) clears the valid bits and loads the register
// defaults; there is no clearing pass. Depends on tsfs_pkg and tsfs_if.
module touch_sample_filter_scale_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsfs_in_if.sink    in_i,
  tsfs_out_if.source out_o,
  tsfs_cfg_if.sink   cfg_i
);

  localparam int NS = tsfs_pkg::PIPE_DEPTH;
  localparam int FS = tsfs_pkg::FRONT_STAGES;
  localparam int DS = tsfs_pkg::DIV_STAGES;

  // Configuration registers.
  logic                          use_pen_irq_q;
  logic [tsfs_pkg::SAMPLE_W-1:0] min_raw_x_q, max_raw_x_q, min_raw_y_q, max_raw_y_q;
  logic [tsfs_pkg::COORD_W-1:0]  screen_width_q, screen_height_q;
  tsfs_pkg::axis_cfg_t           x_cfg, y_cfg;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_pen_irq_q   <= 1'b0;
      min_raw_x_q     <= tsfs_pkg::RST_MIN_RAW;
      max_raw_x_q     <= tsfs_pkg::RST_MAX_RAW;
      min_raw_y_q     <= tsfs_pkg::RST_MIN_RAW;
      max_raw_y_q     <= tsfs_pkg::RST_MAX_RAW;
      screen_width_q  <= tsfs_pkg::RST_SCREEN_WIDTH;
      screen_height_q <= tsfs_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_i.valid) begin
      unique case (tsfs_pkg::cfg_addr_e'(cfg_i.addr))
        tsfs_pkg::CFG_USE_PEN_IRQ:   use_pen_irq_q   <= cfg_i.data[0];
        tsfs_pkg::CFG_MIN_RAW_X:     min_raw_x_q     <= cfg_i.data;
        tsfs_pkg::CFG_MAX_RAW_X:     max_raw_x_q     <= cfg_i.data;
        tsfs_pkg::CFG_MIN_RAW_Y:     min_raw_y_q     <= cfg_i.data;
        tsfs_pkg::CFG_MAX_RAW_Y:     max_raw_y_q     <= cfg_i.data;
        tsfs_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_i.data;
        tsfs_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign x_cfg = '{lo: min_raw_x_q, hi: max_raw_x_q, size: screen_width_q};
  assign y_cfg = '{lo: min_raw_y_q, hi: max_raw_y_q, size: screen_height_q};

  // Pipeline control. A stage may load when the output is ready or when it or
  // any stage after it is empty.
  logic [NS-1:0] v_q, v_d, en;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = out_o.ready || ((v_q >> k) != ({NS{1'b1}} >> k));
      v_d[k] = (k == 0) ? in_i.valid : v_q[(k == 0) ? 0 : k - 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // Front end of both axes.
  tsfs_pkg::axis_words_t x_words, y_words;
  logic                       x_kept, y_kept;
  logic [tsfs_pkg::NUM_W-1:0] x_w [DS+1];
  logic [tsfs_pkg::NUM_W-1:0] y_w [DS+1];
  logic [tsfs_pkg::SUM_W-1:0] x_den [DS+1];
  logic [tsfs_pkg::SUM_W-1:0] y_den [DS+1];

  assign x_words = {in_i.data.x_word_4, in_i.data.x_word_3, in_i.data.x_word_2,
                    in_i.data.x_word_1, in_i.data.x_word_0};
  assign y_words = {in_i.data.y_word_4, in_i.data.y_word_3, in_i.data.y_word_2,
                    in_i.data.y_word_1, in_i.data.y_word_0};

  tsfs_axis_front u_x_front (
    .clk_i   (clk_i),
    .en_i    (en[FS-1:0]),
    .words_i (x_words),
    .cfg_i   (x_cfg),
    .kept_o  (x_kept),
    .num_o   (x_w[0]),
    .den_o   (x_den[0])
  );

  tsfs_axis_front u_y_front (
    .clk_i   (clk_i),
    .en_i    (en[FS-1:0]),
    .words_i (y_words),
    .cfg_i   (y_cfg),
    .kept_o  (y_kept),
    .num_o   (y_w[0]),
    .den_o   (y_den[0])
  );

  for (genvar j = 0; j < DS; j++) begin : g_div
    tsfs_div_stage u_x_div (
      .clk_i (clk_i),
      .en_i  (en[FS+j]),
      .w_i   (x_w[j]),
      .den_i (x_den[j]),
      .w_o   (x_w[j+1]),
      .den_o (x_den[j+1])
    );
    tsfs_div_stage u_y_div (
      .clk_i (clk_i),
      .en_i  (en[FS+j]),
      .w_i   (y_w[j]),
      .den_i (y_den[j]),
      .w_o   (y_w[j+1]),
      .den_o (y_den[j+1])
    );
  end

  // Touch flag travels beside the data: the pen kill is known at stage 0,
  // the sample counts at stage 1.
  logic kill0_q, kill1_q;
  logic touch_q [2:NS-2];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      kill0_q <= use_pen_irq_q && in_i.data.pen_up;
    end
    if (en[1]) begin
      kill1_q <= kill0_q;
    end
    if (en[2]) begin
      touch_q[2] <= !kill1_q && x_kept && y_kept;
    end
    for (int k = 3; k <= NS - 2; k++) begin
      if (en[k]) begin
        touch_q[k] <= touch_q[k-1];
      end
    end
  end

  // Output register. A zero divisor means an empty window span.
  tsfs_pkg::out_item_t out_d, out_q;

  always_comb begin
    out_d.touched = touch_q[NS-2];
    out_d.x_coord = '0;
    out_d.y_coord = '0;
    if (touch_q[NS-2] && (x_den[DS] != '0)) begin
      out_d.x_coord = x_w[DS][tsfs_pkg::COORD_W-1:0];
    end
    if (touch_q[NS-2] && (y_den[DS] != '0)) begin
      out_d.y_coord = y_w[DS][tsfs_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = v_q[NS-1];
  assign out_o.data  = out_q;

endmodule

// File: sv/tsfs_axis_front.sv
// Front end of one axis: window filter, sum and count, offset removal and
// the multiply by the screen size, in four register stages.
// Depends on tsfs_pkg.
module tsfs_axis_front (
  input  logic                                 clk_i,
  input  logic [tsfs_pkg::FRONT_STAGES-1:0]    en_i,
  input  tsfs_pkg::axis_words_t                words_i,
  input  tsfs_pkg::axis_cfg_t                  cfg_i,
  output logic                                 kept_o,
  output logic [tsfs_pkg::NUM_W-1:0]           num_o,
  output logic [tsfs_pkg::SUM_W-1:0]           den_o
);

  logic [tsfs_pkg::SAMPLE_W-1:0] sample_d [tsfs_pkg::SAMPLES_PER_AXIS];
  logic [tsfs_pkg::SAMPLE_W-1:0] sample_q [tsfs_pkg::SAMPLES_PER_AXIS];
  logic [tsfs_pkg::SAMPLES_PER_AXIS-1:0] keep_d, keep_q;

  logic [tsfs_pkg::SUM_W-1:0] sum_d, sum_q;
  logic [tsfs_pkg::CNT_W-1:0] cnt_d, cnt_q;

  logic [tsfs_pkg::SUM_W-1:0] lo_tot;
  logic [tsfs_pkg::SUM_W-1:0] diff_d, diff_q;
  logic [tsfs_pkg::SUM_W-1:0] den2_d, den2_q;
  logic [tsfs_pkg::SAMPLE_W-1:0] span;

  logic [tsfs_pkg::NUM_W-1:0] num_d, num_q;
  logic [tsfs_pkg::SUM_W-1:0] den3_q;

  // Stage 0: samples outside the window are dropped to zero.
  always_comb begin
    for (int i = 0; i < tsfs_pkg::SAMPLES_PER_AXIS; i++) begin
      sample_d[i] = words_i[i][tsfs_pkg::SAMPLE_SHIFT +: tsfs_pkg::SAMPLE_W];
      keep_d[i]   = (sample_d[i] >= cfg_i.lo) && (sample_d[i] <= cfg_i.hi);
      if (!keep_d[i]) begin
        sample_d[i] = '0;
      end
    end
  end

  // Stage 1: sum and count of the kept samples.
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < tsfs_pkg::SAMPLES_PER_AXIS; i++) begin
      sum_d = sum_d + tsfs_pkg::SUM_W'(sample_q[i]);
    end
    cnt_d = tsfs_pkg::CNT_W'($countones(keep_q));
  end

  // Stage 2: the average times the count, less the minimum, over the count
  // times the window span. Both products stay below the sum width.
  always_comb begin
    lo_tot = tsfs_pkg::SUM_W'(tsfs_pkg::SUM_W'(cnt_q) * tsfs_pkg::SUM_W'(cfg_i.lo));
    diff_d = sum_q - lo_tot;
    span   = cfg_i.hi - cfg_i.lo;
    den2_d = tsfs_pkg::SUM_W'(tsfs_pkg::SUM_W'(cnt_q) * tsfs_pkg::SUM_W'(span));
  end

  // Stage 3: scale the numerator by the screen size.
  assign num_d = tsfs_pkg::NUM_W'(tsfs_pkg::NUM_W'(diff_q) * tsfs_pkg::NUM_W'(cfg_i.size));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sample_q <= sample_d;
      keep_q   <= keep_d;
    end
    if (en_i[1]) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (en_i[2]) begin
      diff_q <= diff_d;
      den2_q <= den2_d;
    end
    if (en_i[3]) begin
      num_q  <= num_d;
      den3_q <= den2_q;
    end
  end

  assign kept_o = (cnt_q != '0);
  assign num_o  = num_q;
  assign den_o  = den3_q;

endmodule

// File: sv/tsfs_div_stage.sv
// One stage of the pipelined restoring divider: resolves DIV_STEPS quotient
// bits. The working word holds the partial remainder on top and the
// remaining numerator bits, then the quotient bits, below. Depends on tsfs_pkg.
module tsfs_div_stage (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tsfs_pkg::NUM_W-1:0]  w_i,
  input  logic [tsfs_pkg::SUM_W-1:0]  den_i,
  output logic [tsfs_pkg::NUM_W-1:0]  w_o,
  output logic [tsfs_pkg::SUM_W-1:0]  den_o
);

  logic [tsfs_pkg::NUM_W-1:0] w_d, w_q;
  logic [tsfs_pkg::SUM_W-1:0] den_q;

  // The quotient is below 2**COORD_W, so the top of the numerator is already
  // smaller than the divisor and only COORD_W steps are needed in all.
  always_comb begin
    logic [tsfs_pkg::SUM_W:0] t;
    logic                     qb;
    w_d = w_i;
    for (int s = 0; s < tsfs_pkg::DIV_STEPS; s++) begin
      t  = w_d[tsfs_pkg::NUM_W-1 -: tsfs_pkg::SUM_W+1];
      qb = (t >= {1'b0, den_i});
      if (qb) begin
        t = t - {1'b0, den_i};
      end
      w_d = {t[tsfs_pkg::SUM_W-1:0], w_d[tsfs_pkg::COORD_W-2:0], qb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q   <= w_d;
      den_q <= den_i;
    end
  end

  assign w_o   = w_q;
  assign den_o = den_q;

endmodule

// File: sv/tsfs_checker.sv
// Port-level checker for the touch sample filter and scaler, with its bind.
// Tracks items in flight and checks the result channel.
// Depends on tsfs_pkg and touch_sample_filter_scale_top.
module tsfs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         touched_i,
  input logic [tsfs_pkg::COORD_W-1:0] x_coord_i,
  input logic [tsfs_pkg::COORD_W-1:0] y_coord_i
);

  localparam int CNT_W = $clog2(tsfs_pkg::PIPE_DEPTH + 1);

  logic             in_xfer, out_xfer;
  logic [CNT_W-1:0] inflight_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(touched_i) && $stable(x_coord_i) && $stable(y_coord_i))
    else $error("result changed while stalled");

  a_no_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !touched_i |-> (x_coord_i == '0) && (y_coord_i == '0))
    else $error("coordinates not zero without a touch");

  // Every result belongs to an earlier input transfer.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != '0)
    else $error("result without a pending item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(tsfs_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

endmodule

bind touch_sample_filter_scale_top tsfs_checker u_tsfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .touched_i   (out_o.data.touched),
  .x_coord_i   (out_o.data.x_coord),
  .y_coord_i   (out_o.data.y_coord)
);

// File: bench/tb_top.sv
// Testbench for touch_sample_filter_scale_top: touch reads in, scaled points out.
// A directed table runs first, then random calibrations with random reads, checked against fixed
// points or an in-bench model of the filter and scaler. Depends on tsfs_pkg and tsfs_if.
module tb_top;
  import tsfs_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 6;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_PHASE      = 3;
  localparam int FAST_PHASE      = 5;
  localparam int LONG_HOLD       = 64;
  localparam int MAX_REPORTS     = 10;
  localparam int LIMIT_CYCLES    = 300000;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic                  is_write;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              read;
    logic                  fixed;
    out_item_t             point;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tsfs_in_if  in_if ();
  tsfs_out_if out_if ();
  tsfs_cfg_if cfg_if ();

  touch_sample_filter_scale_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Bench copy of the calibration registers.
  logic                pen_sense;
  logic [SAMPLE_W-1:0] win_lo_x, win_hi_x, win_lo_y, win_hi_y;
  logic [COORD_W-1:0]  scr_w, scr_h;

  out_item_t  point_q[$];
  stim_row_t  directed[$];
  int         fail_count = 0;
  int         burst_left = 0;
  bit         no_gaps = 1'b0;
  bit         hold_req = 1'b0;
  bit         fixed_pending = 1'b0;
  out_item_t  fixed_point;

  // One axis: keep samples inside the window, average, map onto the screen.
  // Returns whether any sample was kept.
  function automatic bit axis_coord(input axis_words_t words, input logic [SAMPLE_W-1:0] lo,
                                    input logic [SAMPLE_W-1:0] hi,
                                    input logic [COORD_W-1:0] size,
                                    output logic [COORD_W-1:0] coord);
    logic [31:0]         total;
    logic [3:0]          kept;
    logic [SAMPLE_W-1:0] smp;
    logic [47:0]         num;
    logic [47:0]         den;
    total = '0;
    kept  = '0;
    for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
      smp = SAMPLE_W'(words[i] >> SAMPLE_SHIFT);
      if (smp >= lo && smp <= hi) begin
        total += 32'(smp);
        kept++;
      end
    end
    coord = '0;
    if (kept != 0 && hi > lo) begin
      num   = (48'(total) - 48'(kept) * 48'(lo)) * 48'(size);
      den   = 48'(kept) * 48'(hi - lo);
      coord = COORD_W'(num / den);
    end
    return kept != 0;
  endfunction

  function automatic out_item_t predict_point(input in_item_t rd);
    out_item_t          res;
    logic [COORD_W-1:0] xc, yc;
    bit                 x_ok, y_ok;
    axis_words_t        xw, yw;
    res = '0;
    if (pen_sense && rd.pen_up) return res;
    xw   = {rd.x_word_4, rd.x_word_3, rd.x_word_2, rd.x_word_1, rd.x_word_0};
    yw   = {rd.y_word_4, rd.y_word_3, rd.y_word_2, rd.y_word_1, rd.y_word_0};
    x_ok = axis_coord(xw, win_lo_x, win_hi_x, scr_w, xc);
    y_ok = axis_coord(yw, win_lo_y, win_hi_y, scr_h, yc);
    if (x_ok && y_ok) begin
      res.touched = 1'b1;
      res.x_coord = xc;
      res.y_coord = yc;
    end
    return res;
  endfunction

  function automatic in_item_t make_read(input logic pen, input axis_words_t xw,
                                         input axis_words_t yw);
    in_item_t rd;
    rd.pen_up   = pen;
    rd.x_word_0 = xw[0];
    rd.x_word_1 = xw[1];
    rd.x_word_2 = xw[2];
    rd.x_word_3 = xw[3];
    rd.x_word_4 = xw[4];
    rd.y_word_0 = yw[0];
    rd.y_word_1 = yw[1];
    rd.y_word_2 = yw[2];
    rd.y_word_3 = yw[3];
    rd.y_word_4 = yw[4];
    return rd;
  endfunction

  // Mostly samples inside the window, some on its edges, the rest anywhere.
  function automatic word_t draw_word(input logic [SAMPLE_W-1:0] lo,
                                      input logic [SAMPLE_W-1:0] hi);
    logic [SAMPLE_W-1:0] smp;
    int                  pick;
    pick = $urandom_range(0, 7);
    if (lo > hi || pick == 0)
      smp = SAMPLE_W'($urandom_range(0, 4095));
    else if (pick == 1)
      smp = lo;
    else if (pick == 2)
      smp = hi;
    else
      smp = SAMPLE_W'($urandom_range(lo, hi));
    return {smp, 4'($urandom)};
  endfunction

  function automatic void pick_window(input int sel, output logic [SAMPLE_W-1:0] lo,
                                      output logic [SAMPLE_W-1:0] hi);
    case (sel)
      0: begin
        lo = 12'd0;
        hi = 12'd4095;
      end
      5, 6: begin
        lo = SAMPLE_W'($urandom_range(0, 4090));
        hi = SAMPLE_W'(lo + $urandom_range(0, 5));
      end
      7: begin
        hi = SAMPLE_W'($urandom_range(0, 4000));
        lo = SAMPLE_W'($urandom_range(hi + 1, 4095));
      end
      default: begin
        lo = SAMPLE_W'($urandom_range(0, 4000));
        hi = SAMPLE_W'($urandom_range(lo + 1, 4095));
      end
    endcase
  endfunction

  function automatic void add_write(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    directed.push_back(row);
  endfunction

  function automatic void add_read(input in_item_t rd, input logic fixed,
                                   input out_item_t point);
    stim_row_t row;
    row       = '0;
    row.read  = rd;
    row.fixed = fixed;
    row.point = point;
    directed.push_back(row);
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_USE_PEN_IRQ:   pen_sense = val[0];
      CFG_MIN_RAW_X:     win_lo_x  = val;
      CFG_MAX_RAW_X:     win_hi_x  = val;
      CFG_MIN_RAW_Y:     win_lo_y  = val;
      CFG_MAX_RAW_Y:     win_hi_y  = val;
      CFG_SCREEN_WIDTH:  scr_w     = val;
      CFG_SCREEN_HEIGHT: scr_h     = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Offers one read; valid stays high across a burst and drops only for a gap.
  task automatic push_read(input in_item_t rd, input logic fixed, input out_item_t point);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    fixed_pending = fixed;
    fixed_point   = point;
    in_if.valid  <= 1'b1;
    in_if.data   <= rd;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
  endtask

  // Stops offering and waits until every pending point has come back.
  task automatic drain_points();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (point_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Result side is handled before the input side, so a point that shows up
  // too early can never pair with the read accepted at the same edge.
  always @(posedge clk_i) begin : check_points
    out_item_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (point_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected point: touched %0d x %0d y %0d",
                     out_if.data.touched, out_if.data.x_coord, out_if.data.y_coord);
        end else begin
          want = point_q.pop_front();
          compare_field("touched", want.touched, out_if.data.touched);
          compare_field("x_coord", want.x_coord, out_if.data.x_coord);
          compare_field("y_coord", want.y_coord, out_if.data.y_coord);
        end
      end
      if (in_if.valid && in_if.ready)
        point_q.push_back(fixed_pending ? fixed_point : predict_point(in_if.data));
    end
  end

  // Receiver: a new stall pattern is drawn whenever the current one runs out; a hold request
  // keeps ready low long enough for the pipeline to back up into the input.
  initial begin : drive_ready
    int pattern;
    int stretch;
    int tick;
    pattern = 0;
    stretch = 0;
    tick    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          pattern = $urandom_range(0, 3);
          stretch = $urandom_range(20, 120);
        end
        stretch--;
        tick++;
        case (pattern)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= (tick % 3 != 0);
          default: out_if.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin : run_limit
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("touch_sample_filter_scale_top verification failed");
    $finish;
  end

  initial begin : run_stimulus
    stim_row_t           row;
    axis_words_t         xw, yw;
    logic [SAMPLE_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [COORD_W-1:0]  scr;
    int                  n_rows;

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.addr  = '0;
    cfg_if.data  = '0;
    pen_sense    = 1'b0;
    win_lo_x     = RST_MIN_RAW;
    win_hi_x     = RST_MAX_RAW;
    win_lo_y     = RST_MIN_RAW;
    win_hi_y     = RST_MAX_RAW;
    scr_w        = RST_SCREEN_WIDTH;
    scr_h        = RST_SCREEN_HEIGHT;
    fixed_point  = '0;

    // Reset defaults: full window, 320 by 240, pen level ignored.
    add_read(make_read(1'b0, {5{16'h0000}}, {5{16'h0000}}), 1'b1, {1'b1, 12'd0, 12'd0});
    add_read(make_read(1'b1, {5{16'hFFFF}}, {5{16'hFFFF}}), 1'b1, {1'b1, 12'd320, 12'd240});
    add_read(make_read(1'b0, {5{16'h000F}}, {5{16'h000F}}), 1'b1, {1'b1, 12'd0, 12'd0});
    add_read(make_read(1'b0, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0FED},
                       {16'hFEDC, 16'hBA98, 16'h7654, 16'h3210, 16'h8421}), 1'b0, '0);
    // Pen sensing on; the upper data bits are dropped by the 1-bit register.
    add_write(CFG_USE_PEN_IRQ, 12'hFFF);
    add_read(make_read(1'b1, {5{16'h8000}}, {5{16'h8000}}), 1'b1, {1'b0, 12'd0, 12'd0});
    add_read(make_read(1'b0, {5{16'hFFFF}}, {5{16'hFFFF}}), 1'b1, {1'b1, 12'd320, 12'd240});
    // Narrow X window: nothing kept, then samples on and just past both edges.
    add_write(CFG_MIN_RAW_X, 12'd100);
    add_write(CFG_MAX_RAW_X, 12'd200);
    add_read(make_read(1'b0, {16'h0320, 16'h0630, 16'h0C90, 16'hFFF0, 16'h0000},
                       {5{16'h8000}}), 1'b1, {1'b0, 12'd0, 12'd0});
    add_read(make_read(1'b0, {16'h0640, 16'h0C80, 16'h0960, 16'h0630, 16'h0C90},
                       {5{16'h4000}}), 1'b0, '0);
    // Y window of a single value still reports a touch with a zero coordinate.
    add_write(CFG_MIN_RAW_Y, 12'd500);
    add_write(CFG_MAX_RAW_Y, 12'd500);
    add_read(make_read(1'b0, {5{16'h0960}}, {5{16'h1F40}}), 1'b0, '0);
    // Minimum above maximum keeps nothing.
    add_write(CFG_MIN_RAW_Y, 12'd600);
    add_read(make_read(1'b0, {5{16'h0960}}, {5{16'h1F40}}), 1'b1, {1'b0, 12'd0, 12'd0});
    // Full windows with the largest and smallest screen sizes.
    add_write(CFG_MIN_RAW_X, 12'd0);
    add_write(CFG_MAX_RAW_X, 12'd4095);
    add_write(CFG_MIN_RAW_Y, 12'd0);
    add_write(CFG_MAX_RAW_Y, 12'd4095);
    add_write(CFG_SCREEN_WIDTH, 12'd4095);
    add_write(CFG_SCREEN_HEIGHT, 12'd1);
    add_read(make_read(1'b0, {5{16'hFFFF}}, {5{16'hFFFF}}), 1'b1, {1'b1, 12'd4095, 12'd1});
    add_read(make_read(1'b0, {16'h0010, 16'hFFFF, 16'h7FF8, 16'h8001, 16'h1234},
                       {16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0, 16'h3C3C}), 1'b0, '0);
    // A zero screen size pins the coordinate to zero.
    add_write(CFG_SCREEN_WIDTH, 12'd0);
    add_write(CFG_SCREEN_HEIGHT, 12'd0);
    add_read(make_read(1'b0, {5{16'hFFFF}}, {5{16'hFFFF}}), 1'b1, {1'b1, 12'd0, 12'd0});
    // Pen sensing off through a masked value; an unmapped index changes nothing.
    add_write(CFG_USE_PEN_IRQ, 12'hFFE);
    add_write(CFG_UNMAPPED, 12'hFFF);
    add_write(CFG_SCREEN_WIDTH, 12'd320);
    add_write(CFG_SCREEN_HEIGHT, 12'd240);
    add_read(make_read(1'b1, {5{16'hFFFF}}, {5{16'hFFFF}}), 1'b1, {1'b1, 12'd320, 12'd240});
    add_read(make_read(1'b1, {16'hC3C3, 16'h2222, 16'hE001, 16'h0FF0, 16'h7777},
                       {16'h1111, 16'hEEEE, 16'h4000, 16'hBFFF, 16'h0001}), 1'b0, '0);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    n_rows = directed.size();
    for (int r = 0; r < n_rows; r++) begin
      row = directed[r];
      if (row.is_write) begin
        drain_points();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        push_read(row.read, row.fixed, row.point);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_points();
      pick_window((phase == 0) ? 0 : $urandom_range(0, 7), lo_x, hi_x);
      pick_window((phase == 0) ? 0 : $urandom_range(0, 7), lo_y, hi_y);
      scr = (phase == 0) ? 12'd4095 : (phase == 1) ? 12'd1 : 12'($urandom_range(1, 4095));
      write_reg(CFG_USE_PEN_IRQ, 12'($urandom_range(0, 4095)));
      write_reg(CFG_MIN_RAW_X, lo_x);
      write_reg(CFG_MAX_RAW_X, hi_x);
      write_reg(CFG_MIN_RAW_Y, lo_y);
      write_reg(CFG_MAX_RAW_Y, hi_y);
      write_reg(CFG_SCREEN_WIDTH, scr);
      write_reg(CFG_SCREEN_HEIGHT, (phase < 2) ? scr : 12'($urandom_range(1, 4095)));
      no_gaps = (phase == FAST_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == HOLD_PHASE && n == 0) begin
          hold_req = 1'b1;
          no_gaps  = 1'b1;
        end
        if (phase == HOLD_PHASE && n == 48)
          no_gaps = 1'b0;
        for (int k = 0; k < SAMPLES_PER_AXIS; k++) begin
          xw[k] = draw_word(lo_x, hi_x);
          yw[k] = draw_word(lo_y, hi_y);
        end
        push_read(make_read($urandom_range(0, 4) == 0, xw, yw), 1'b0, '0);
      end
    end

    drain_points();
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (fail_count == 0)
      $display("touch_sample_filter_scale_top verification clean");
    else
      $display("touch_sample_filter_scale_top verification failed");
    $finish;
  end

endmodule

// File: files.f
sv/tsfs_pkg.sv
sv/tsfs_if.sv
sv/tsfs_axis_front.sv
sv/tsfs_div_stage.sv
sv/touch_sample_filter_scale_top.sv
sv/tsfs_checker.sv
bench/tb_top.sv
